// ===== rtl/afc_pkg.sv =====
// afc_pkg: types, constants and lane helpers for the frustum cull block
// used by every module under rtl
package afc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_BITS = 16;
  localparam int REG_COUNT  = 6;
  localparam int NPL = (NUM_PLANES < REG_COUNT) ? NUM_PLANES : REG_COUNT;
  localparam int FIELD_W = 48;
  localparam int CB = COORD_BITS;
  localparam int C2W = CB + 1;
  localparam int PRW = C2W + 16;
  localparam int WW  = PRW + 3;
  localparam int DW  = WW + 16 + 2;
  localparam int IDXW = 3;

  localparam logic [1:0] REASON_KEPT = 2'd0;
  localparam logic [1:0] REASON_FLAG = 2'd1;
  localparam logic [1:0] REASON_OUT  = 2'd2;
  localparam logic [2:0] PLANE_NONE  = 3'd6;

  typedef struct packed {
    logic        object_visible;
    logic [47:0] box_min;
    logic [47:0] box_max;
    logic [47:0] axis_x_column;
    logic [47:0] axis_y_column;
    logic [47:0] axis_z_column;
    logic [47:0] translation;
  } in_word_t;

  typedef struct packed {
    logic       keep;
    logic [1:0] cull_reason;
    logic [2:0] failed_plane;
  } out_word_t;

  typedef logic signed [WW-1:0] wcoord_t;

  typedef struct packed {
    logic    vld;
    logic    decided;
    logic    keep;
    logic [1:0] reason;
    logic [2:0] plane;
    wcoord_t [2:0] wmin;
    wcoord_t [2:0] wmax;
  } cell_t;

  function automatic logic signed [CB-1:0] pos_lane(input logic [FIELD_W-1:0] f,
                                                    input int k);
    logic [FIELD_W+3*CB-1:0] e;
    e = {{(3*CB){1'b0}}, f};
    return e[k*CB +: CB];
  endfunction

  function automatic logic signed [15:0] lane16(input logic [63:0] f, input int k);
    return f[k*16 +: 16];
  endfunction

endpackage

// ===== rtl/afc_xform.sv =====
// afc_xform: world box from local box and affine transform, three stages
// depends on afc_pkg
module afc_xform (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  afc_pkg::in_word_t in_word,
  output afc_pkg::cell_t    out_cell
);
  import afc_pkg::*;

  logic s1_vld_r, s2_vld_r;
  logic s1_dec_r, s2_dec_r;
  logic [1:0] s1_rsn_r, s2_rsn_r;
  logic signed [C2W-1:0] c2_r [3];
  logic signed [C2W-1:0] h2_r [3];
  logic signed [15:0] m_r [3][3];
  logic signed [CB-1:0] t_r [3];
  logic signed [PRW-1:0] pc_r [3][3];
  logic signed [PRW-1:0] pe_r [3][3];
  logic signed [WW-1:0] tw_r [3];
  cell_t cell_r;

  logic s1_nz;
  always_comb begin
    s1_nz = 1'b0;
    for (int j = 0; j < 3; j++)
      if (pos_lane(in_word.box_min, j) != '0 || pos_lane(in_word.box_max, j) != '0)
        s1_nz = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      cell_r.vld <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      cell_r.vld <= s2_vld_r;
    end
    s1_dec_r <= !in_word.object_visible || !s1_nz;
    s1_rsn_r <= in_word.object_visible ? REASON_KEPT : REASON_FLAG;
    for (int j = 0; j < 3; j++) begin
      c2_r[j] <= C2W'(pos_lane(in_word.box_min, j)) + C2W'(pos_lane(in_word.box_max, j));
      h2_r[j] <= C2W'(pos_lane(in_word.box_max, j)) - C2W'(pos_lane(in_word.box_min, j));
      t_r[j]  <= pos_lane(in_word.translation, j);
      m_r[j][0] <= lane16({16'd0, in_word.axis_x_column}, j);
      m_r[j][1] <= lane16({16'd0, in_word.axis_y_column}, j);
      m_r[j][2] <= lane16({16'd0, in_word.axis_z_column}, j);
    end
    s2_dec_r <= s1_dec_r;
    s2_rsn_r <= s1_rsn_r;
    for (int r = 0; r < 3; r++) begin
      tw_r[r] <= WW'(t_r[r]) <<< 13;
      for (int j = 0; j < 3; j++) begin
        pc_r[r][j] <= PRW'(m_r[r][j]) * PRW'(c2_r[j]);
        pe_r[r][j] <= (m_r[r][j] < 0 ? -PRW'(m_r[r][j]) : PRW'(m_r[r][j])) * PRW'(h2_r[j]);
      end
    end
    cell_r.decided <= s2_dec_r;
    cell_r.keep    <= (s2_rsn_r == REASON_KEPT);
    cell_r.reason  <= s2_rsn_r;
    cell_r.plane   <= PLANE_NONE;
    for (int r = 0; r < 3; r++) begin
      cell_r.wmin[r] <= tw_r[r] + WW'(pc_r[r][0]) + WW'(pc_r[r][1]) + WW'(pc_r[r][2])
                      - WW'(pe_r[r][0]) - WW'(pe_r[r][1]) - WW'(pe_r[r][2]);
      cell_r.wmax[r] <= tw_r[r] + WW'(pc_r[r][0]) + WW'(pc_r[r][1]) + WW'(pc_r[r][2])
                      + WW'(pe_r[r][0]) + WW'(pe_r[r][1]) + WW'(pe_r[r][2]);
    end
  end

  assign out_cell = cell_r;
endmodule

// ===== rtl/afc_plane_cell.sv =====
// afc_plane_cell: one plane test, two stages, passes the box to the next cell
// depends on afc_pkg
module afc_plane_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [63:0]              plane,
  input  logic [afc_pkg::IDXW-1:0] plane_idx,
  input  afc_pkg::cell_t           up_cell,
  output afc_pkg::cell_t           dn_cell
);
  import afc_pkg::*;

  cell_t mid_r, out_r;
  logic signed [DW-1:0] prod_r [3];
  logic signed [DW-1:0] off_r;
  logic signed [DW-1:0] plane_dist;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.vld <= 1'b0;
      out_r.vld <= 1'b0;
    end else begin
      mid_r.vld <= up_cell.vld;
      out_r.vld <= mid_r.vld;
    end
    {mid_r.decided, mid_r.keep, mid_r.reason, mid_r.plane, mid_r.wmin, mid_r.wmax} <=
      {up_cell.decided, up_cell.keep, up_cell.reason, up_cell.plane,
       up_cell.wmin, up_cell.wmax};
    off_r <= DW'(lane16(plane, 3)) <<< 27;
    for (int r = 0; r < 3; r++)
      prod_r[r] <= DW'(lane16(plane, r)) *
                   DW'(lane16(plane, r) >= 0 ? up_cell.wmax[r] : up_cell.wmin[r]);
    {out_r.wmin, out_r.wmax} <= {mid_r.wmin, mid_r.wmax};
    if (!mid_r.decided && plane_dist < 0) begin
      out_r.decided <= 1'b1;
      out_r.keep    <= 1'b0;
      out_r.reason  <= REASON_OUT;
      out_r.plane   <= plane_idx;
    end else begin
      out_r.decided <= mid_r.decided;
      out_r.keep    <= mid_r.keep;
      out_r.reason  <= mid_r.reason;
      out_r.plane   <= mid_r.plane;
    end
  end

  assign plane_dist = off_r + prod_r[0] + prod_r[1] + prod_r[2];
  assign dn_cell = out_r;
endmodule

// ===== rtl/aabb_frustum_cull.sv =====
// aabb_frustum_cull: top level, plane registers, transform front end, plane cell row
// depends on afc_pkg, afc_xform, afc_plane_cell
//
// channel | ports                                  | handshake
// input   | start, busy, in_word                   | taken when start && !busy
// result  | out_strobe, out_word                   | one cycle, no stall
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | taken when valid && ready
//
// one object per cycle; each object passes the transform stages, then each plane
// cell in turn. busy is always low; results cannot be stalled.
// reset clears the plane registers and all valid bits.
module aabb_frustum_cull (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  afc_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output afc_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import afc_pkg::*;

  logic [63:0] plane_r [REG_COUNT];
  cell_t chain [NPL+1];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) plane_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < REG_COUNT; i++)
        if (cfg_index == 3'(i)) plane_r[i] <= cfg_data;
    end
  end

  afc_xform u_xform (
    .clk(clk), .rst_n(rst_n), .in_vld(start && !busy), .in_word(in_word),
    .out_cell(chain[0])
  );

  for (genvar g = 0; g < NPL; g++) begin : g_cell
    afc_plane_cell u_cell (
      .clk(clk), .rst_n(rst_n), .plane(plane_r[g]), .plane_idx(IDXW'(g)),
      .up_cell(chain[g]), .dn_cell(chain[g+1])
    );
  end

  assign out_strobe = chain[NPL].vld;
  assign out_word.keep = chain[NPL].keep;
  assign out_word.cull_reason = chain[NPL].reason;
  assign out_word.failed_plane = chain[NPL].plane;

  a_keep_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.keep == (out_word.cull_reason == REASON_KEPT)))
    else $error("keep and reason disagree");
  a_plane_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_word.failed_plane != PLANE_NONE) ==
                    (out_word.cull_reason == REASON_OUT)))
    else $error("plane and reason disagree");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(3 + 2*NPL) out_strobe)
    else $error("result missing");
endmodule
